// File: src/tmcb_pkg.sv
// Package for the threshold / centroid / bounding box block.
// Widths, register indexes, payload structs and controller/datapath
// interface types. No dependencies.
`default_nettype none

package tmcb_pkg;

  localparam int MAX_DIM      = 4096;
  localparam int NUM_CHANNELS = 3;
  localparam int CH_W         = 8;
  localparam int POS_W        = $clog2(MAX_DIM);
  localparam int DIM_W        = POS_W + 1;
  localparam int CNT_W        = 2 * POS_W + 1;
  localparam int SUM_W        = CNT_W + POS_W - 1;
  localparam int DIV_STEPS    = POS_W;
  localparam int STEP_W       = $clog2(DIV_STEPS);
  localparam int NCH_W        = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_USED = 2'd3;

  localparam logic [CH_W-1:0]  THRESHOLD_RST     = 8'd128;
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST   = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST  = 13'd480;
  localparam logic [NCH_W-1:0] CHANNELS_USED_RST = 2'd1;

  typedef struct packed {
    logic [CH_W-1:0] chan_a;
    logic [CH_W-1:0] chan_b;
    logic [CH_W-1:0] chan_c;
  } in_pix_t;

  typedef struct packed {
    logic             mask_on;
    logic             frame_done;
    logic [POS_W-1:0] centre_x;
    logic [POS_W-1:0] centre_y;
    logic [POS_W-1:0] box_x;
    logic [POS_W-1:0] box_y;
    logic [POS_W-1:0] box_w;
    logic [POS_W-1:0] box_h;
  } out_res_t;

  typedef struct packed {
    logic pix_take;
    logic load_pix;
    logic div_init;
    logic div_step;
    logic load_sum;
  } ctl_cmd_t;

  typedef struct packed {
    logic frame_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: src/tmcb_datapath.sv
// Datapath: config registers, threshold test, raster position, accumulators,
// shared restoring divider for the centroid, and the result register.
// Depends on tmcb_pkg.
`default_nettype none

module tmcb_datapath
  import tmcb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_pix_t               in_data,
  input  wire ctl_cmd_t              cmd,
  output dp_stat_t                   stat,
  output out_res_t                   out_data
);

  logic [CH_W-1:0]  threshold_r;
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic [NCH_W-1:0] channels_used_r;

  logic [POS_W-1:0] col_pos_r, row_pos_r;
  logic [CNT_W-1:0] count_r;
  logic [SUM_W-1:0] sum_col_r, sum_row_r;
  logic [POS_W-1:0] min_col_r, max_col_r, min_row_r, max_row_r;
  logic             any_r;
  logic             mask_hold_r;

  logic [SUM_W-1:0] rem_x_r, rem_y_r, dvs_r;
  logic [POS_W-1:0] qx_r, qy_r;

  out_res_t         out_r;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic             marked, row_end, last;
  logic [CNT_W-1:0] div_n;
  logic             ge_x, ge_y;
  out_res_t         pix_res;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  always_comb begin
    w_eff   = eff_dim(frame_width_r);
    h_eff   = eff_dim(frame_height_r);
    marked  = ((channels_used_r >= NCH_W'(1)) && (in_data.chan_a >= threshold_r)) ||
              ((channels_used_r >= NCH_W'(2)) && (in_data.chan_b >= threshold_r)) ||
              ((channels_used_r >= NCH_W'(3)) && (in_data.chan_c >= threshold_r));
    row_end = {1'b0, col_pos_r} >= (w_eff - DIM_W'(1));
    last    = row_end && ({1'b0, row_pos_r} >= (h_eff - DIM_W'(1)));
    div_n   = (count_r == '0) ? CNT_W'(1) : count_r;
    ge_x    = rem_x_r >= dvs_r;
    ge_y    = rem_y_r >= dvs_r;
    pix_res         = '0;
    pix_res.mask_on = marked;
  end

  assign stat.frame_last = last;
  assign out_data        = out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= THRESHOLD_RST;
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      channels_used_r <= CHANNELS_USED_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_THRESHOLD:     threshold_r     <= cfg_data[CH_W-1:0];
        CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
        CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
        CFG_CHANNELS_USED: channels_used_r <= cfg_data[NCH_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position and frame accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_sum) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      count_r   <= '0;
      sum_col_r <= '0;
      sum_row_r <= '0;
      min_col_r <= '0;
      max_col_r <= '0;
      min_row_r <= '0;
      max_row_r <= '0;
      any_r     <= 1'b0;
    end else if (cmd.pix_take) begin
      if (marked) begin
        count_r   <= count_r + CNT_W'(1);
        sum_col_r <= sum_col_r + SUM_W'(col_pos_r);
        sum_row_r <= sum_row_r + SUM_W'(row_pos_r);
        any_r     <= 1'b1;
        if (!any_r) begin
          min_col_r <= col_pos_r;
          max_col_r <= col_pos_r;
          min_row_r <= row_pos_r;
          max_row_r <= row_pos_r;
        end else begin
          if (col_pos_r < min_col_r) min_col_r <= col_pos_r;
          if (col_pos_r > max_col_r) max_col_r <= col_pos_r;
          if (row_pos_r < min_row_r) min_row_r <= row_pos_r;
          if (row_pos_r > max_row_r) max_row_r <= row_pos_r;
        end
      end
      if (!last) begin
        if (row_end) begin
          col_pos_r <= '0;
          row_pos_r <= row_pos_r + POS_W'(1);
        end else begin
          col_pos_r <= col_pos_r + POS_W'(1);
        end
      end
    end
  end

  // restoring divider, one quotient bit per step, quotient known below 2^POS_W
  always_ff @(posedge clk) begin
    if (cmd.pix_take) begin
      mask_hold_r <= marked;
    end
    if (cmd.div_init) begin
      rem_x_r <= sum_col_r;
      rem_y_r <= sum_row_r;
      dvs_r   <= {div_n, {(POS_W-1){1'b0}}};
      qx_r    <= '0;
      qy_r    <= '0;
    end else if (cmd.div_step) begin
      if (ge_x) rem_x_r <= rem_x_r - dvs_r;
      if (ge_y) rem_y_r <= rem_y_r - dvs_r;
      qx_r  <= {qx_r[POS_W-2:0], ge_x};
      qy_r  <= {qy_r[POS_W-2:0], ge_y};
      dvs_r <= dvs_r >> 1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      out_r            <= pix_res;
    end else if (cmd.load_sum) begin
      out_r.mask_on    <= mask_hold_r;
      out_r.frame_done <= 1'b1;
      out_r.centre_x   <= qx_r;
      out_r.centre_y   <= qy_r;
      out_r.box_x      <= any_r ? min_col_r : '0;
      out_r.box_y      <= any_r ? min_row_r : '0;
      out_r.box_w      <= any_r ? (max_col_r - min_col_r) : '0;
      out_r.box_h      <= any_r ? (max_row_r - min_row_r) : '0;
    end
  end

endmodule

`default_nettype wire

// File: src/tmcb_ctrl.sv
// Controller: input/output handshakes, result valid flag and the sequence
// for the end-of-frame division. Depends on tmcb_pkg.
`default_nettype none

module tmcb_ctrl
  import tmcb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DINIT = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free, take;

  always_comb begin
    out_free      = !out_valid_r || out_ready;
    in_ready      = (state_r == S_IDLE) && out_free;
    take          = in_valid && in_ready;
    cmd           = '0;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.pix_take = 1'b1;
          if (stat.frame_last) begin
            state_nxt = S_DINIT;
          end else begin
            cmd.load_pix  = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_sum  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/threshold_mask_centroid_bbox_unit.sv
// Threshold mask with per-frame centroid and bounding box.
// Pixels enter on in_valid/in_ready as in_data (chan_a..chan_c) in raster
// order; each transfer yields one result on out_valid/out_ready as out_data.
// A pixel is marked when any tested channel is at or above threshold.
// Ordinary pixels: result is registered in the cycle after the input transfer,
// and a new pixel is taken every cycle while the receiver keeps up.
// Last pixel of a frame: the centroid comes from a shared restoring divider
// that produces one quotient bit per cycle for X and Y together; the
// result (frame_done = 1, centroid and box) follows the accumulate, the
// divider load, 12 divide steps and the result load, which waits for the
// receiver to be free; in_ready is low until the result is loaded.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while idle. Index 0 threshold, 1 frame_width,
// 2 frame_height, 3 channels_used.
// Reset (synchronous, rst_n low) restores register defaults (128, 640, 480,
// 1) and clears position and accumulators. If the receiver stalls the result
// register holds and in_ready drops until the result transfers.
// Depends on tmcb_pkg, tmcb_ctrl, tmcb_datapath.
`default_nettype none

module threshold_mask_centroid_bbox_unit
  import tmcb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_pix_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_res_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tmcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmcb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // end-of-frame pixel blocks input while the divider runs
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && stat.frame_last) |=> !in_ready)
    else $error("input taken during centroid division");

  // summary fields are zero on ordinary pixels
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.frame_done) |->
      (out_data.centre_x == '0 && out_data.centre_y == '0 &&
       out_data.box_x == '0 && out_data.box_y == '0 &&
       out_data.box_w == '0 && out_data.box_h == '0))
    else $error("summary fields set off frame end");

  // an ordinary pixel transfer produces a result the next cycle
  a_pix_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !stat.frame_last) |=>
      (out_valid && !out_data.frame_done))
    else $error("missing pixel result");

endmodule

`default_nettype wire

// File: tb/tb_threshold_mask_centroid_bbox_unit.sv
`timescale 1ns / 100ps
// Testbench for threshold_mask_centroid_bbox_unit: random pixel streams in raster order,
// checked per pixel (mask) and per frame (centroid, bounding box) against a predictor.
// Depends on tmcb_pkg and the unit's RTL; needs no other files.

module tb_threshold_mask_centroid_bbox_unit;
  import tmcb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HICCUP} rx_mode_e;

  class blob_summary_check;
    logic [CH_W-1:0]  thr;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [NCH_W-1:0] nch;
    int unsigned      col, row, min_x, max_x, min_y, max_y;
    longint unsigned  cnt, sum_x, sum_y;
    bit               seen;
    out_res_t         awaited_results[$];
    int               errors, pixels, frames, marks;

    function new();
      thr        = THRESHOLD_RST;
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      nch        = CHANNELS_USED_RST;
      restart_frame();
    endfunction

    function void restart_frame();
      col = 0; row = 0; cnt = 0; sum_x = 0; sum_y = 0;
      min_x = 0; max_x = 0; min_y = 0; max_y = 0; seen = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_THRESHOLD:     thr = d[CH_W-1:0];
        CFG_FRAME_WIDTH:   width_reg = d;
        CFG_FRAME_HEIGHT:  height_reg = d;
        CFG_CHANNELS_USED: nch = d[NCH_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_pixel(in_pix_t p);
      logic [CH_W-1:0] ch [3];
      int unsigned     w, h, n;
      longint unsigned div;
      bit              hit, row_end, last;
      out_res_t        r;
      ch[0] = p.chan_a;
      ch[1] = p.chan_b;
      ch[2] = p.chan_c;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      n = (nch > NUM_CHANNELS) ? NUM_CHANNELS : nch;
      hit = 0;
      for (int i = 0; i < n; i++)
        if (ch[i] >= thr) hit = 1;
      if (hit) begin
        marks++;
        cnt++;
        sum_x += col;
        sum_y += row;
        if (!seen) begin
          min_x = col; max_x = col; min_y = row; max_y = row;
          seen = 1;
        end else begin
          if (col < min_x) min_x = col;
          if (col > max_x) max_x = col;
          if (row < min_y) min_y = row;
          if (row > max_y) max_y = row;
        end
      end
      row_end = col >= w - 1;
      last = row_end && row >= h - 1;
      r = '0;
      r.mask_on = hit;
      r.frame_done = last;
      if (last) begin
        div = (cnt == 0) ? 1 : cnt;
        r.centre_x = POS_W'(sum_x / div);
        r.centre_y = POS_W'(sum_y / div);
        if (seen) begin
          r.box_x = POS_W'(min_x);
          r.box_y = POS_W'(min_y);
          r.box_w = POS_W'(max_x - min_x);
          r.box_h = POS_W'(max_y - min_y);
        end
        frames++;
        restart_frame();
      end else if (row_end) begin
        col = 0;
        row++;
      end else begin
        col++;
      end
      pixels++;
      awaited_results.insert(awaited_results.size(), r);
    endfunction

    function void compare(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (awaited_results.size() == 0) begin
        $error("result transfer with no pixel pending: %p", got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare("mask_on", POS_W'(want.mask_on), POS_W'(got.mask_on));
      compare("frame_done", POS_W'(want.frame_done), POS_W'(got.frame_done));
      compare("centre_x", want.centre_x, got.centre_x);
      compare("centre_y", want.centre_y, got.centre_y);
      compare("box_x", want.box_x, got.box_x);
      compare("box_y", want.box_y, got.box_y);
      compare("box_w", want.box_w, got.box_w);
      compare("box_h", want.box_h, got.box_h);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_pix_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_res_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  blob_summary_check sb;
  int unsigned       cycles = 0;
  int                burst_left = 0;
  int                stall_left = 0;
  rx_mode_e          stall_mode = RX_OPEN;
  int                cfg_writes = 0;
  int                random_sent = 0;

  threshold_mask_centroid_bbox_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.awaited_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_e'($urandom_range(3));
      stall_left = $urandom_range(200, 20);
    end
    stall_left--;
    case (stall_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(1));
      RX_SPARSE: out_ready <= (cycles % 4 == 0);
      default:   out_ready <= ($urandom_range(7) != 0);
    endcase
  end

  function automatic in_pix_t pix(int a, int b, int c);
    in_pix_t p;
    p.chan_a = CH_W'(a);
    p.chan_b = CH_W'(b);
    p.chan_c = CH_W'(c);
    return p;
  endfunction

  // density: percent chance per channel of a value at or above threshold, apart from values at and just below it
  function automatic logic [CH_W-1:0] chan_value(logic [CH_W-1:0] thr, int density);
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return thr;
    if (pick < 10) return thr - 1;
    if ($urandom_range(99) < density) return CH_W'($urandom_range(255, thr));
    if (thr == 0) return '0;
    return CH_W'($urandom_range(thr - 1, 0));
  endfunction

  function automatic in_pix_t make_pixel(int density);
    return pix(chan_value(sb.thr, density), chan_value(sb.thr, density),
               chan_value(sb.thr, density));
  endfunction

  task automatic send_pixel(input in_pix_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data <= in_pix_t'($urandom);
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    sb.take_pixel(p);
    @(negedge clk);
  endtask

  task automatic run_pixels(int n, int density);
    repeat (n) send_pixel(make_pixel(density));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int wh, n, density;
    logic [CFG_DATA_W-1:0] d;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: threshold 128, only chan_a tested
    send_pixel(pix(127, 255, 255));
    send_pixel(pix(128, 0, 0));
    send_pixel(pix(255, 0, 0));
    send_pixel(pix(0, 200, 200));
    settle();
    // shrink the frame mid-row: column 4 is past the new last column
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    send_pixel(pix(0, 0, 0));
    settle();

    // upper data bits ignored: threshold 255, all three channels
    write_reg(CFG_THRESHOLD, 13'h1FFF);
    write_reg(CFG_CHANNELS_USED, 13'h1FFF);
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    send_pixel(pix(254, 254, 254));
    send_pixel(pix(0, 0, 255));
    send_pixel(pix(0, 255, 0));
    send_pixel(pix(255, 0, 0));
    send_pixel(pix(0, 0, 0));
    send_pixel(pix(254, 0, 0));
    settle();

    // no channel tested: nothing marked even at threshold 0
    write_reg(CFG_THRESHOLD, 13'd0);
    write_reg(CFG_CHANNELS_USED, 13'd0);
    run_pixels(6, 100);
    settle();

    // zero sizes behave as 1x1
    write_reg(CFG_CHANNELS_USED, 13'd2);
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    send_pixel(pix(0, 0, 0));
    settle();

    write_reg(CFG_THRESHOLD, 13'h0AFF);
    write_reg(CFG_CHANNELS_USED, 13'h0005);
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    send_pixel(pix(0, 255, 255));
    send_pixel(pix(255, 0, 0));
    send_pixel(pix(254, 255, 255));
    send_pixel(pix(255, 255, 255));
    settle();

    // largest dimensions: a long row, then a tall column, each ended by a shrink
    write_reg(CFG_THRESHOLD, 13'd200);
    write_reg(CFG_CHANNELS_USED, 13'd3);
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    run_pixels(100, 5);
    settle();
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    run_pixels(1, 50);
    settle();
    write_reg(CFG_FRAME_HEIGHT, 13'd4096);
    run_pixels(100, 5);
    settle();
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    run_pixels(1, 50);

    while (random_sent < 700) begin
      settle();
      if ($urandom_range(99) < 60) begin
        d = CFG_DATA_W'($urandom);
        case ($urandom_range(9))
          0: d[CH_W-1:0] = '0;
          1: d[CH_W-1:0] = 8'd255;
          2: d[CH_W-1:0] = 8'd1;
          default: d[CH_W-1:0] = CH_W'($urandom_range(255));
        endcase
        write_reg(CFG_THRESHOLD, d);
      end
      if ($urandom_range(99) < 60) begin
        case ($urandom_range(9))
          0: d = '0;
          1: d = CFG_DATA_W'(1);
          2, 3: d = CFG_DATA_W'($urandom_range(40, 9));
          default: d = CFG_DATA_W'($urandom_range(8, 1));
        endcase
        write_reg(CFG_FRAME_WIDTH, d);
      end
      if ($urandom_range(99) < 60) begin
        case ($urandom_range(9))
          0: d = '0;
          1: d = CFG_DATA_W'($urandom_range(12, 1));
          default: d = CFG_DATA_W'($urandom_range(6, 1));
        endcase
        write_reg(CFG_FRAME_HEIGHT, d);
      end
      if ($urandom_range(99) < 60) begin
        d = CFG_DATA_W'($urandom);
        write_reg(CFG_CHANNELS_USED, d);
      end
      case ($urandom_range(4))
        0: density = 0;
        1: density = 5;
        2: density = 30;
        3: density = 70;
        default: density = 100;
      endcase
      wh = sb.clamp_dim(sb.width_reg) * sb.clamp_dim(sb.height_reg);
      n = wh * $urandom_range(3, 1);
      // leave some frames unfinished so the next settings land mid-frame
      if (wh > 1 && $urandom_range(99) < 15) n += $urandom_range(wh - 1, 1);
      run_pixels(n, density);
      random_sent += n;
    end

    settle();
    repeat (16) @(negedge clk);
    $display("checked %0d pixels (%0d marked) over %0d completed frames", sb.pixels,
             sb.marks, sb.frames);
    $display("%0d register writes, %0d mismatches, %0d cycles", cfg_writes, sb.errors,
             cycles);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
src/tmcb_pkg.sv
src/tmcb_datapath.sv
src/tmcb_ctrl.sv
src/threshold_mask_centroid_bbox_unit.sv
tb/tb_threshold_mask_centroid_bbox_unit.sv
